[hdl/hex_string_to_signed_128_assert.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef HEX_STRING_TO_SIGNED_128_ASSERT_SVH
`define HEX_STRING_TO_SIGNED_128_ASSERT_SVH

// expr must never hold while out of reset
`define HXS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed");

// cause in one cycle implies effect in the same cycle
`define HXS_ASSERT_SAME(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cause) |-> (effect)) \
        else $error("assertion failed");

// cause in one cycle implies effect in the next cycle
`define HXS_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cause) |=> (effect)) \
        else $error("assertion failed");

`endif

[hdl/hxs_pkg.sv]
package hxs_pkg;

    localparam int ACC_W      = 128;
    localparam int HALF_W     = 64;
    localparam int ACC_DIGITS = 32;
    localparam int CNT_W      = 6;
    localparam int WIDTH_W    = 8;
    localparam int STATUS_W   = 2;

    localparam logic [CNT_W-1:0]   CNT_SAT       = 6'd33;
    localparam logic [CNT_W-1:0]   CNT_ACC_LIMIT = 6'd32;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 8'd128;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_X_LOW   = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_A_LOW   = 8'h61;
    localparam logic [7:0] CH_F_LOW   = 8'h66;
    localparam logic [7:0] CH_A_UP    = 8'h41;
    localparam logic [7:0] CH_F_UP    = 8'h46;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_DIGITS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_WIDTH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    // snapshot of one finished literal
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic               too_short;
        logic               text_bad;
        logic [CNT_W-1:0]   digit_count;
        logic [ACC_W-1:0]   accum;
    } t_lit_end;

    // {valid, digit value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
            return {1'b1, v[3:0]};
        end else if (c >= CH_A_LOW && c <= CH_F_LOW) begin
            v = c - CH_A_LOW + HEX_TEN;
            return {1'b1, v[3:0]};
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            v = c - CH_A_UP + HEX_TEN;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

[hdl/hxs_result.sv]
module hxs_result #(
    parameter int MAX_WIDTH = 128
) (
    input  hxs_pkg::t_lit_end                 i_lit,
    output logic [hxs_pkg::ACC_W-1:0]         o_value,
    output logic [hxs_pkg::STATUS_W-1:0]      o_status
);
    import hxs_pkg::*;

    logic [WIDTH_W:0]   width_ext;
    logic [WIDTH_W:0]   digit_limit;
    logic               width_bad;
    logic               too_many;
    logic [ACC_W-1:0]   mask;
    logic [6:0]         sign_idx;
    logic               sign;
    logic [HALF_W-1:0]  upper;
    logic               narrow_ovf;
    logic [ACC_W-1:0]   extended;

    always_comb begin
        width_ext   = {1'b0, i_lit.width};
        // ceil(width/4) digits allowed
        digit_limit = (width_ext + 9'd3) >> 2;
        width_bad   = (i_lit.width == '0) || (width_ext > (WIDTH_W+1)'(MAX_WIDTH));
        too_many    = {3'b000, i_lit.digit_count} > digit_limit;

        // width 128 is the only valid width with bit 7 set
        mask     = i_lit.width[7] ? '1 : ~({ACC_W{1'b1}} << i_lit.width[6:0]);
        sign_idx = i_lit.width[6:0] - 7'd1;
        sign     = i_lit.accum[sign_idx];

        upper      = i_lit.accum[HALF_W-1:0] & ~mask[HALF_W-1:0];
        narrow_ovf = (width_ext < 9'd64) && (upper != '0) &&
                     ((upper != ~mask[HALF_W-1:0]) || !sign);

        extended = sign ? (i_lit.accum | ~mask) : (i_lit.accum & mask);

        o_value = '0;
        priority if (width_bad) begin
            o_status = ST_BAD_WIDTH;
        end else if (i_lit.too_short || i_lit.text_bad) begin
            o_status = ST_MALFORMED;
        end else if (too_many || narrow_ovf) begin
            o_status = ST_OVERFLOW;
        end else begin
            o_status = ST_OK;
            o_value  = extended;
        end
    end

endmodule

[hdl/hex_string_to_signed_128.sv]
// Channel   Dir  Beat contents                                  Handshake
// s_axis    in   tdata[7:0] char_code, tlast is_last            tvalid/tready
// m_axis    out  tdata value_low[63:0], value_high[127:64],     tvalid/tready
//                tuser[1:0] status
// cfg       in   i_cfg_wdata[7:0] value_width                   i_cfg_we
//
// One character beat per cycle while the output is not stalled. The latch stage
// holds the finished literal from its last character; when the output is free,
// it is formatted (sign extension, overflow check) into the output register.
// Reset (synchronous, active low) clears parser state, valids, width = 128.
// A stalled output holds its beat; the latch stage fills, then s_axis_tready
// drops until the output drains.
module hex_string_to_signed_128 #(
    parameter int MAX_WIDTH = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config
    input  logic                               i_cfg_we,
    input  logic [hxs_pkg::WIDTH_W-1:0]        i_cfg_wdata,   // value_width
    // character stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [7:0] char_code
    input  logic                               s_axis_tlast,  // is_last
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [hxs_pkg::ACC_W-1:0]          m_axis_tdata,  // [63:0] value_low, [127:64] value_high
    output logic [hxs_pkg::STATUS_W-1:0]       m_axis_tuser   // [1:0] status
);
    import hxs_pkg::*;

    // parser state
    logic [WIDTH_W-1:0] r_width;
    logic [1:0]         r_pos,        n_pos;
    logic               r_prefix_bad, n_prefix_bad;
    logic               r_bad_char,   n_bad_char;
    logic               r_seen_nz,    n_seen_nz;
    logic [CNT_W-1:0]   r_count,      n_count;
    logic [ACC_W-1:0]   r_accum,      n_accum;

    // latch and output stages
    t_lit_end           r_lit;
    logic               r_lit_valid;
    logic [ACC_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic               r_out_valid;

    logic [ACC_W-1:0]    fmt_value;
    logic [STATUS_W-1:0] fmt_status;
    logic [4:0]          hex;
    logic                out_free;
    logic                lit_move;
    logic                in_beat;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign lit_move      = r_lit_valid && out_free;
    assign s_axis_tready = !r_lit_valid || out_free;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign hex           = hex_value(s_axis_tdata);

    // per-character update
    always_comb begin
        n_pos        = r_pos;
        n_prefix_bad = r_prefix_bad;
        n_bad_char   = r_bad_char;
        n_seen_nz    = r_seen_nz;
        n_count      = r_count;
        n_accum      = r_accum;
        unique case (r_pos)
            POS_FIRST: begin
                if (s_axis_tdata != CH_ZERO) n_prefix_bad = 1'b1;
                n_pos = POS_SECOND;
            end
            POS_SECOND: begin
                if (s_axis_tdata != CH_X_LOW && s_axis_tdata != CH_X_UP) n_prefix_bad = 1'b1;
                n_pos = POS_DIGITS;
            end
            default: begin
                if (!hex[4]) begin
                    n_bad_char = 1'b1;
                end else if (r_seen_nz || hex[3:0] != 4'd0) begin
                    // leading zeros skipped; digits past the 32nd only counted
                    n_seen_nz = 1'b1;
                    if (r_count < CNT_ACC_LIMIT) n_accum = {r_accum[ACC_W-5:0], hex[3:0]};
                    if (r_count < CNT_SAT) n_count = r_count + 6'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_pos        <= POS_FIRST;
            r_prefix_bad <= 1'b0;
            r_bad_char   <= 1'b0;
            r_seen_nz    <= 1'b0;
            r_count      <= '0;
            r_accum      <= '0;
            r_lit_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_width <= i_cfg_wdata;

            if (in_beat) begin
                if (s_axis_tlast) begin
                    // literal done: start fresh
                    r_pos        <= POS_FIRST;
                    r_prefix_bad <= 1'b0;
                    r_bad_char   <= 1'b0;
                    r_seen_nz    <= 1'b0;
                    r_count      <= '0;
                    r_accum      <= '0;
                end else begin
                    r_pos        <= n_pos;
                    r_prefix_bad <= n_prefix_bad;
                    r_bad_char   <= n_bad_char;
                    r_seen_nz    <= n_seen_nz;
                    r_count      <= n_count;
                    r_accum      <= n_accum;
                end
            end

            if (in_beat && s_axis_tlast) r_lit_valid <= 1'b1;
            else if (lit_move)           r_lit_valid <= 1'b0;

            if (lit_move)           r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat && s_axis_tlast) begin
            r_lit.width       <= r_width;
            r_lit.too_short   <= (r_pos != POS_DIGITS);
            r_lit.text_bad    <= n_prefix_bad || n_bad_char;
            r_lit.digit_count <= n_count;
            r_lit.accum       <= n_accum;
        end
        if (lit_move) begin
            r_out_value  <= fmt_value;
            r_out_status <= fmt_status;
        end
    end

    hxs_result #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_result (
        .i_lit    (r_lit),
        .o_value  (fmt_value),
        .o_status (fmt_status)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

`include "hex_string_to_signed_128_assert.svh"

    `HXS_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, in_beat && s_axis_tlast, r_pos == POS_FIRST && r_count == '0)
    `HXS_ASSERT_NEVER(a_count_sat, i_clk, i_rst_n, r_count > CNT_SAT)
    `HXS_ASSERT_SAME(a_error_zero, i_clk, i_rst_n, r_out_valid && r_out_status != ST_OK, r_out_value == '0)
    `HXS_ASSERT_SAME(a_backpressure, i_clk, i_rst_n, r_lit_valid && r_out_valid && !m_axis_tready, !s_axis_tready)

endmodule

[bench/hex_literal_checker.sv]
`timescale 1ns / 1ps
module hex_literal_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hxs_pkg::WIDTH_W-1:0]  i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] char_code
    input  logic                         s_axis_tlast,   // is_last
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [hxs_pkg::ACC_W-1:0]    m_axis_tdata,   // [63:0] value_low, [127:64] value_high
    input  logic [hxs_pkg::STATUS_W-1:0] m_axis_tuser,   // [1:0] status
    output int                           o_fail_count,
    output int                           o_pending
);
    import hxs_pkg::*;

    typedef struct packed {
        logic [HALF_W-1:0]   value_low;
        logic [HALF_W-1:0]   value_high;
        logic [STATUS_W-1:0] status;
    } t_parse_result;

    t_parse_result      expected_values[$];
    logic [WIDTH_W-1:0] width_q;
    logic [1:0]         lit_pos;
    logic               lit_prefix_bad;
    logic               lit_bad_char;
    logic               lit_seen_nz;
    logic [CNT_W-1:0]   lit_digits;
    logic [ACC_W-1:0]   lit_accum;
    int                 fail_count = 0;

    // {is digit, digit value}
    function automatic logic [4:0] decode_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
        if (c >= CH_A_LOW && c <= CH_F_LOW) return {1'b1, 4'(c - CH_A_LOW + HEX_TEN)};
        if (c >= CH_A_UP && c <= CH_F_UP) return {1'b1, 4'(c - CH_A_UP + HEX_TEN)};
        return 5'd0;
    endfunction

    task automatic clear_literal();
        lit_pos        = POS_FIRST;
        lit_prefix_bad = 1'b0;
        lit_bad_char   = 1'b0;
        lit_seen_nz    = 1'b0;
        lit_digits     = '0;
        lit_accum      = '0;
    endtask

    // result of the finished literal; pos is the position of its last char
    function automatic t_parse_result format_literal(input logic [1:0] pos);
        t_parse_result     r;
        int                w;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] mask;
        logic [HALF_W-1:0] upper;
        logic              sgn;
        r        = '0;
        r.status = ST_OK;
        w        = width_q;
        lo       = lit_accum[HALF_W-1:0];
        hi       = lit_accum[ACC_W-1:HALF_W];
        if (w < 1 || w > ACC_W) begin
            r.status = ST_BAD_WIDTH;
        end else if (pos != POS_DIGITS || lit_prefix_bad || lit_bad_char) begin
            r.status = ST_MALFORMED;
        end else if (int'(lit_digits) > (w + 3) / 4) begin
            r.status = ST_OVERFLOW;
        end else if (w == ACC_W) begin
            r.value_low  = lo;
            r.value_high = hi;
        end else if (w == HALF_W) begin
            r.value_low  = lo;
            r.value_high = {HALF_W{lo[HALF_W-1]}};
        end else if (w < HALF_W) begin
            // bits above the width must be absent or a true sign extension
            mask  = (64'd1 << w) - 64'd1;
            sgn   = lo[w-1];
            upper = lo & ~mask;
            if (upper != '0 && (upper != ~mask || !sgn)) begin
                r.status = ST_OVERFLOW;
            end else begin
                r.value_low  = sgn ? (lo | ~mask) : (lo & mask);
                r.value_high = {HALF_W{sgn}};
            end
        end else begin
            // 65..127: stray top bits are overwritten by the sign
            mask         = (64'd1 << (w - HALF_W)) - 64'd1;
            sgn          = hi[w-HALF_W-1];
            r.value_low  = lo;
            r.value_high = sgn ? (hi | ~mask) : (hi & mask);
        end
        return r;
    endfunction

    task automatic absorb_char(input logic [7:0] c, input logic last);
        logic [4:0] dg;
        logic [1:0] pos;
        pos = lit_pos;
        dg  = decode_digit(c);
        if (pos == POS_FIRST) begin
            if (c != CH_ZERO) lit_prefix_bad = 1'b1;
        end else if (pos == POS_SECOND) begin
            if (c != CH_X_LOW && c != CH_X_UP) lit_prefix_bad = 1'b1;
        end else if (!dg[4]) begin
            lit_bad_char = 1'b1;
        end else if (lit_seen_nz || dg[3:0] != 4'd0) begin
            lit_seen_nz = 1'b1;
            if (lit_digits < CNT_ACC_LIMIT) lit_accum = {lit_accum[ACC_W-5:0], dg[3:0]};
            if (lit_digits < CNT_SAT) lit_digits = lit_digits + 6'd1;
        end
        if (pos != POS_DIGITS) lit_pos = pos + 2'd1;
        if (last) begin
            expected_values.push_back(format_literal(pos));
            clear_literal();
        end
    endtask

    task automatic check_result();
        t_parse_result want;
        t_parse_result got;
        got.value_low  = m_axis_tdata[HALF_W-1:0];
        got.value_high = m_axis_tdata[ACC_W-1:HALF_W];
        got.status     = m_axis_tuser;
        if (expected_values.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result beat: lo=%h hi=%h status=%0d",
                         got.value_low, got.value_high, got.status);
        end else begin
            want = expected_values.pop_front();
            if (got.value_low !== want.value_low || got.value_high !== want.value_high ||
                got.status !== want.status) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: exp lo=%h hi=%h status=%0d, got lo=%h hi=%h status=%0d",
                             want.value_low, want.value_high, want.status,
                             got.value_low, got.value_high, got.status);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_q = WIDTH_RESET;
            clear_literal();
            expected_values.delete();
        end else begin
            if (i_cfg_we) width_q = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) absorb_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) check_result();
        end
        o_pending    <= expected_values.size();
        o_fail_count <= fail_count;
    end

endmodule

[bench/tb_hex_string_to_signed_128.sv]
`timescale 1ns / 1ps
module tb_hex_string_to_signed_128;
    import hxs_pkg::*;

    // Stimulus sizing: about 1300 random chars spread across the width phases
    localparam int CHARS_PER_PHASE = 48;
    localparam int DRAIN_CYCLES    = 8;       // settle margin after all results drain
    localparam int HOLD_CYCLES     = 400;     // long receiver hold-off
    localparam int CYCLE_LIMIT     = 200000;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [WIDTH_W-1:0]  i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;   // [7:0] char_code
    logic                s_axis_tlast  = 1'b0; // is_last
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [ACC_W-1:0]    m_axis_tdata;         // [63:0] value_low, [127:64] value_high
    logic [STATUS_W-1:0] m_axis_tuser;         // [1:0] status

    int       fail_count;
    int       pending;
    logic [7:0] lit_chars[$];   // characters of the literal being sent
    int       burst_left   = 0;
    bit       tx_no_gaps   = 1'b1;
    t_rx_mode rx_mode      = RX_STEADY;
    int       hold_request = 0;
    int       hold_seen    = 0;
    int       hold_left    = 0;
    logic [7:0] rx_pattern = 8'b1011_0110;
    int       cycle_count  = 0;

    // Clock: 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    hex_string_to_signed_128 #(
        .MAX_WIDTH(ACC_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hex_literal_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Receiver: its own stall pattern per mode, plus a long hold-off whenever
    // the stimulus bumps hold_request. The hold is counted here, not in the driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request != hold_seen) begin
            hold_seen     <= hold_request;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
            case (rx_mode)
                RX_STEADY: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:   m_axis_tready <= rx_pattern[0];
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One char beat. Bursts of random length, with random gaps between them unless
    // tx_no_gaps is set; tvalid stays high across back-to-back beats.
    task automatic send_beat(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (tx_no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
    endtask

    // Drop valid, wait until every expected result has drained, then let the
    // pipeline settle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Builds one literal for width w into lit_chars. Mostly well formed with
    // digit counts around the width's digit budget; the rest is byte noise or
    // a well-formed literal with one char corrupted or cut short.
    task automatic build_literal(input int w);
        int           kind;
        int           nlead;
        int           ndig;
        int           cap;
        int           pick;
        logic [ACC_W-1:0]  v;
        logic [HALF_W-1:0] keep;
        logic [3:0]   d;
        lit_chars.delete();
        kind = $urandom_range(0, 99);
        cap  = (w >= 1 && w <= ACC_W) ? (w + 3) / 4 : $urandom_range(1, ACC_DIGITS);
        if (kind < 8) begin
            repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        lit_chars.push_back(CH_ZERO);
        lit_chars.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LOW);
        pick  = $urandom_range(0, 9);
        nlead = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        pick  = $urandom_range(0, 99);
        if (pick < 8)       ndig = 0;
        else if (pick < 50) ndig = $urandom_range(1, cap);
        else if (pick < 80) ndig = cap;
        else if (pick < 92) ndig = cap + $urandom_range(1, 2);
        else                ndig = $urandom_range(cap + 1, 40);
        if (ndig == 0 && nlead == 0) nlead = 1;
        v = {$urandom, $urandom, $urandom, $urandom};
        // narrow widths: negative values whose top digits carry the sign all the way
        if (w >= 1 && w < HALF_W && $urandom_range(0, 2) == 0) begin
            keep             = (64'd1 << (w - 1)) - 64'd1;
            v[HALF_W-1:0]    = v[HALF_W-1:0] | ~keep;
            ndig             = cap;
        end
        repeat (nlead) lit_chars.push_back(CH_ZERO);
        for (int i = ndig - 1; i >= 0; i--) begin
            d = (i < ACC_DIGITS) ? v[4*i +: 4] : 4'($urandom);
            if (i == ndig - 1 && d == 4'd0) d = 4'($urandom_range(1, 15));
            lit_chars.push_back(d < 4'd10 ? CH_ZERO + 8'(d) :
                                ($urandom_range(0, 1) ? CH_A_UP : CH_A_LOW) + 8'(d) - HEX_TEN);
        end
        if (kind < 20) begin
            pick = $urandom_range(0, lit_chars.size() - 1);
            if (kind < 14) begin
                lit_chars[pick] = 8'($urandom_range(0, 255));
            end else begin
                while (lit_chars.size() > pick + 1) lit_chars.pop_back();
            end
        end
    endtask

    initial begin
        int phase_widths[$];
        int phase_chars;
        phase_widths = '{1, 2, 4, 5, 8, 17, 31, 32, 33, 63, 64, 65, 66, 100, 127, 128,
                         0, 129, 255};
        repeat (3) phase_widths.push_back($urandom_range(1, ACC_W));
        phase_widths.push_back($urandom_range(0, 255));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed literals at the reset width (128): zero, too short on the
        // first and second char, bad prefix chars, a non-hex digit, mixed case,
        // leading zeros, and a char with the top bit set.
        send_text("0x0");
        send_text("0");
        send_text("0x");
        send_text("1x1");
        send_text("0y1");
        send_text("0x1g");
        send_text("0XaF");
        send_text("0x00fA9");
        send_beat(CH_ZERO, 1'b0);
        send_beat(CH_X_LOW, 1'b0);
        send_beat(8'hFF, 1'b1);

        // Width phases: extremes, digit-boundary widths, the bad widths, then
        // random ones. Receiver modes rotate; two phases get a long hold-off
        // while the sender keeps pushing, so the block backs up.
        foreach (phase_widths[p]) begin
            write_width(WIDTH_W'(phase_widths[p]));
            tx_no_gaps = (p % 4 == 0);
            rx_mode    <= t_rx_mode'(p % 3);
            if (p == 4 || p == 12) hold_request <= hold_request + 1;
            phase_chars = 0;
            while (phase_chars < CHARS_PER_PHASE) begin
                build_literal(phase_widths[p]);
                phase_chars += lit_chars.size();
                foreach (lit_chars[i]) send_beat(lit_chars[i], i == lit_chars.size() - 1);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
